>>> sv/tibd_pkg.sv
// Shared constants and types for the tape image block deframer.
`timescale 1ns / 1ps
`default_nettype none
package tibd_pkg;

   // Block ID bytes
   localparam logic [7:0] ID_STANDARD = 8'h10;
   localparam logic [7:0] ID_TURBO    = 8'h11;
   localparam logic [7:0] ID_PAUSE    = 8'h20;

   // Header bytes skipped after a turbo block ID (0 to 15)
   localparam logic [3:0] TURBO_HEADER_BYTES = 4'd15;

   // Command queue between parser and serializer
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Work for the serializer caused by one input word
   typedef struct packed {
      logic        has_bits;
      logic [7:0]  data;
      logic        has_pause;
      logic [15:0] pause_ms;
   } cmd_type;

   // Result word fields
   localparam logic RSP_KIND_BIT   = 1'b0;
   localparam logic RSP_KIND_PAUSE = 1'b1;

endpackage
`default_nettype wire

>>> sv/tibd_front.sv
// Block framing parser: takes image words and issues serializer commands.
`timescale 1ns / 1ps
`default_nettype none
module tibd_front
   import tibd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] data_byte,
   output logic            cmd_push,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      PH_ID       = 4'd0,
      PH_STD_P0   = 4'd1,
      PH_STD_P1   = 4'd2,
      PH_STD_L0   = 4'd3,
      PH_STD_L1   = 4'd4,
      PH_TRB_SKIP = 4'd5,
      PH_TRB_L0   = 4'd6,
      PH_TRB_L1   = 4'd7,
      PH_TRB_L2   = 4'd8,
      PH_DATA     = 4'd9,
      PH_PAU_P0   = 4'd10,
      PH_PAU_P1   = 4'd11
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  skip_ff, skip_in;
   logic [23:0] remaining_ff, remaining_in;
   logic [15:0] pause_ff, pause_in;
   logic        standard_ff, standard_in;

   logic [15:0] len16;
   logic [23:0] len24;
   logic [23:0] rem_dec;
   logic [3:0]  skip_dec;
   logic [15:0] pause_full;

   assign len16      = {data_byte, remaining_ff[7:0]};
   assign len24      = {data_byte, remaining_ff[15:0]};
   assign rem_dec    = remaining_ff - 24'd1;
   assign skip_dec   = skip_ff - 4'd1;
   assign pause_full = {data_byte, pause_ff[7:0]};

   always_comb begin
      phase_in     = phase_ff;
      skip_in      = skip_ff;
      remaining_in = remaining_ff;
      pause_in     = pause_ff;
      standard_in  = standard_ff;
      cmd_push     = 1'b0;
      cmd          = '0;
      if (take) begin
         unique case (phase_ff)
            PH_STD_P0: begin
               pause_in = {8'd0, data_byte};
               phase_in = PH_STD_P1;
            end
            PH_STD_P1: begin
               pause_in = pause_full;
               phase_in = PH_STD_L0;
            end
            PH_STD_L0: begin
               remaining_in = {16'd0, data_byte};
               phase_in     = PH_STD_L1;
            end
            PH_STD_L1: begin
               remaining_in = {8'd0, len16};
               if (len16 == 16'd0) begin
                  cmd_push      = 1'b1;
                  cmd.has_pause = 1'b1;
                  cmd.pause_ms  = pause_ff;
                  phase_in      = PH_ID;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_TRB_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 4'd0) begin
                  phase_in = PH_TRB_L0;
               end
            end
            PH_TRB_L0: begin
               remaining_in = {16'd0, data_byte};
               phase_in     = PH_TRB_L1;
            end
            PH_TRB_L1: begin
               remaining_in = {8'd0, len16};
               phase_in     = PH_TRB_L2;
            end
            PH_TRB_L2: begin
               remaining_in = len24;
               phase_in     = (len24 == 24'd0) ? PH_ID : PH_DATA;
            end
            PH_DATA: begin
               cmd_push     = 1'b1;
               cmd.has_bits = 1'b1;
               cmd.data     = data_byte;
               remaining_in = rem_dec;
               if (rem_dec == 24'd0) begin
                  cmd.has_pause = standard_ff;
                  cmd.pause_ms  = standard_ff ? pause_ff : 16'd0;
                  phase_in      = PH_ID;
               end
            end
            PH_PAU_P0: begin
               pause_in = {8'd0, data_byte};
               phase_in = PH_PAU_P1;
            end
            PH_PAU_P1: begin
               pause_in      = pause_full;
               cmd_push      = 1'b1;
               cmd.has_pause = 1'b1;
               cmd.pause_ms  = pause_full;
               phase_in      = PH_ID;
            end
            default: begin
               // block ID byte; unknown IDs are dropped
               if (data_byte == ID_STANDARD) begin
                  standard_in = 1'b1;
                  phase_in    = PH_STD_P0;
               end else if (data_byte == ID_TURBO) begin
                  standard_in = 1'b0;
                  skip_in     = TURBO_HEADER_BYTES;
                  phase_in    = (TURBO_HEADER_BYTES == 4'd0) ? PH_TRB_L0 : PH_TRB_SKIP;
               end else if (data_byte == ID_PAUSE) begin
                  phase_in = PH_PAU_P0;
               end else begin
                  phase_in = PH_ID;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ID;
         skip_ff      <= 4'd0;
         remaining_ff <= 24'd0;
         pause_ff     <= 16'd0;
         standard_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         skip_ff      <= skip_in;
         remaining_ff <= remaining_in;
         pause_ff     <= pause_in;
         standard_ff  <= standard_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/tibd_queue.sv
// Short command queue between the parser and the serializer.
`timescale 1ns / 1ps
`default_nettype none
module tibd_queue
   import tibd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> sv/tibd_back.sv
// Serializer: turns queued commands into bit and pause result words.
`timescale 1ns / 1ps
`default_nettype none
module tibd_back
   import tibd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire cmd_type head_cmd,
   output logic         pop,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [23:0]  rsp_tdata,
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   logic [2:0]  idx_ff, idx_in;
   logic        bits_done_ff, bits_done_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic        bit_ff, bit_in;
   logic [15:0] ms_ff, ms_in;
   logic        last_ff, last_in;
   logic        advance, emit_bit, last_bit;

   assign advance  = !valid_ff || rsp_tready;
   assign emit_bit = head_cmd.has_bits && !bits_done_ff;
   assign last_bit = (idx_ff == 3'd7);

   always_comb begin
      idx_in       = idx_ff;
      bits_done_in = bits_done_ff;
      valid_in     = valid_ff;
      kind_in      = kind_ff;
      bit_in       = bit_ff;
      ms_in        = ms_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      if (advance) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (emit_bit) begin
               // send MSB first
               kind_in = RSP_KIND_BIT;
               bit_in  = head_cmd.data[3'd7 - idx_ff];
               ms_in   = 16'd0;
               last_in = last_bit && !head_cmd.has_pause;
               if (last_bit) begin
                  idx_in       = 3'd0;
                  bits_done_in = head_cmd.has_pause;
                  pop          = !head_cmd.has_pause;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end else begin
               kind_in      = RSP_KIND_PAUSE;
               bit_in       = 1'b0;
               ms_in        = head_cmd.pause_ms;
               last_in      = 1'b1;
               bits_done_in = 1'b0;
               pop          = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         bits_done_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         bits_done_ff <= bits_done_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      bit_ff  <= bit_in;
      ms_ff   <= ms_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, ms_ff, bit_ff};

endmodule
`default_nettype wire

>>> sv/tape_image_block_deframer.sv
// Top level of the tape image block deframer: parser, command queue, serializer.
//
//   channel  direction  tdata                              tuser  tlast
//   req_     in         [7:0] data_byte                    -      -
//   rsp_     out        [0] bit_value, [16:1] pause_ms     kind   last
//
// The parser takes one word per cycle while the command queue has room.
// A data word becomes eight bit result words, plus the pause after the last
// word of a standard block; the parser takes new words while older ones are
// still being sent. Of header, length and ID words only the high length word
// of an empty standard block and the high word of a pause block queue a pause.
// Reset is synchronous and active high; it empties the queue and output.
// A stall on rsp_ backs up through the queue to req_tready.
`timescale 1ns / 1ps
`default_nettype none
module tape_image_block_deframer
   import tibd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [0] bit_value, [16:1] pause_ms, [23:17] zero
   output logic             rsp_tuser,   // [0] kind
   output logic             rsp_tlast
);

   logic    take;
   logic    cmd_push;
   cmd_type cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   assign req_tready = !queue_full;
   assign take       = req_tvalid && !queue_full;

   tibd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_tdata),
      .cmd_push  (cmd_push),
      .cmd       (cmd)
   );

   tibd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tibd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> tb/tb_tape_image_block_deframer.sv
// Self-checking testbench for the tape image block deframer.
`timescale 1ns / 1ps
module tb_tape_image_block_deframer;
   import tibd_pkg::*;

   localparam int RANDOM_WORDS = 285;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 40;

   typedef enum logic [3:0] {
      WAIT_ID,
      STD_PAUSE_LO,
      STD_PAUSE_HI,
      STD_LEN_LO,
      STD_LEN_HI,
      TURBO_SKIP,
      TURBO_LEN_0,
      TURBO_LEN_1,
      TURBO_LEN_2,
      DATA_BITS,
      GAP_PAUSE_LO,
      GAP_PAUSE_HI
   } parse_phase_type;

   typedef struct packed {
      logic        kind;
      logic        bit_value;
      logic [15:0] pause_ms;
      logic        last;
   } tape_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [0] bit_value, [16:1] pause_ms, [23:17] zero
   logic        rsp_tuser;            // [0] kind
   logic        rsp_tlast;

   tape_image_block_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Shadow copy of the parser state
   parse_phase_type phase = WAIT_ID;
   logic [3:0]   skip_left = 4'd0;
   logic [23:0]  bytes_left = 24'd0;
   logic [15:0]  pause_acc = 16'd0;
   logic         standard_block = 1'b0;

   logic [7:0]   tape_words[$];
   tape_result_type expected_results[$];

   int words_sent = 0;
   int words_total = 0;
   int results_seen = 0;
   int errors = 0;
   int cycles = 0;
   int std_blocks = 0;
   int turbo_blocks = 0;
   int pause_blocks = 0;
   int stray_ids = 0;
   int req_gap = 0;
   int req_steady = 0;
   int rsp_gap = 0;
   int rsp_steady = 0;

   // Advance the shadow parser by one word and queue the results it causes.
   function automatic void predict_word(input logic [7:0] b);
      tape_result_type out_q[$];
      tape_result_type r;
      int n;
      r = '0;
      case (phase)
         STD_PAUSE_LO: begin
            pause_acc = {8'h00, b};
            phase = STD_PAUSE_HI;
         end
         STD_PAUSE_HI: begin
            pause_acc[15:8] = b;
            phase = STD_LEN_LO;
         end
         STD_LEN_LO: begin
            bytes_left = {16'h0000, b};
            phase = STD_LEN_HI;
         end
         STD_LEN_HI: begin
            bytes_left[15:8] = b;
            if (bytes_left == 24'd0) begin
               r.kind = RSP_KIND_PAUSE;
               r.pause_ms = pause_acc;
               out_q.push_back(r);
               phase = WAIT_ID;
            end else begin
               phase = DATA_BITS;
            end
         end
         TURBO_SKIP: begin
            skip_left = skip_left - 4'd1;
            if (skip_left == 4'd0) phase = TURBO_LEN_0;
         end
         TURBO_LEN_0: begin
            bytes_left = {16'h0000, b};
            phase = TURBO_LEN_1;
         end
         TURBO_LEN_1: begin
            bytes_left[15:8] = b;
            phase = TURBO_LEN_2;
         end
         TURBO_LEN_2: begin
            bytes_left[23:16] = b;
            phase = (bytes_left == 24'd0) ? WAIT_ID : DATA_BITS;
         end
         DATA_BITS: begin
            // MSB goes out first
            for (int i = 7; i >= 0; i--) begin
               r = '0;
               r.kind = RSP_KIND_BIT;
               r.bit_value = b[i];
               out_q.push_back(r);
            end
            bytes_left = bytes_left - 24'd1;
            if (bytes_left == 24'd0) begin
               if (standard_block) begin
                  r = '0;
                  r.kind = RSP_KIND_PAUSE;
                  r.pause_ms = pause_acc;
                  out_q.push_back(r);
               end
               phase = WAIT_ID;
            end
         end
         GAP_PAUSE_LO: begin
            pause_acc = {8'h00, b};
            phase = GAP_PAUSE_HI;
         end
         GAP_PAUSE_HI: begin
            pause_acc[15:8] = b;
            r.kind = RSP_KIND_PAUSE;
            r.pause_ms = pause_acc;
            out_q.push_back(r);
            phase = WAIT_ID;
         end
         default: begin
            if (b == ID_STANDARD) begin
               standard_block = 1'b1;
               phase = STD_PAUSE_LO;
            end else if (b == ID_TURBO) begin
               standard_block = 1'b0;
               skip_left = TURBO_HEADER_BYTES;
               phase = (skip_left == 4'd0) ? TURBO_LEN_0 : TURBO_SKIP;
            end else if (b == ID_PAUSE) begin
               phase = GAP_PAUSE_LO;
            end else begin
               phase = WAIT_ID;
            end
         end
      endcase
      n = out_q.size();
      if (n > 0) begin
         r = out_q[n - 1];
         r.last = 1'b1;
         out_q[n - 1] = r;
      end
      foreach (out_q[k]) expected_results.push_back(out_q[k]);
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // Mostly short gaps, a few long ones, and now and then a stretch with none.
   function automatic int pick_gap(inout int steady);
      int r;
      if (steady > 0) begin
         steady--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         steady = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Data bytes now and then look like block IDs.
   function automatic logic [7:0] pick_data();
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 2))
            0: return ID_STANDARD;
            1: return ID_TURBO;
            default: return ID_PAUSE;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_word(input logic [7:0] b);
      tape_words.push_back(b);
   endtask

   task automatic push_standard(input logic [15:0] ms, input logic [15:0] len);
      push_word(ID_STANDARD);
      push_word(ms[7:0]);
      push_word(ms[15:8]);
      push_word(len[7:0]);
      push_word(len[15:8]);
      repeat (len) push_word(pick_data());
      std_blocks++;
   endtask

   task automatic push_turbo(input logic [23:0] len);
      push_word(ID_TURBO);
      repeat (TURBO_HEADER_BYTES) push_word(pick_data());
      push_word(len[7:0]);
      push_word(len[15:8]);
      push_word(len[23:16]);
      repeat (len) push_word(pick_data());
      turbo_blocks++;
   endtask

   task automatic push_pause(input logic [15:0] ms);
      push_word(ID_PAUSE);
      push_word(ms[7:0]);
      push_word(ms[15:8]);
      pause_blocks++;
   endtask

   // Input side: hold the word while stalled, otherwise take a gap or send the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_word(req_tdata);
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (tape_words.size() > 0) begin
               req_tdata <= tape_words.pop_front();
               req_tvalid <= 1'b1;
               req_gap = pick_gap(req_steady);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = pick_gap(rsp_steady);
      end
   end

   always @(posedge clock) begin : result_monitor
      tape_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word: expected none, got kind %0b tdata %h last %0b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            want = expected_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_tuser));
            check_field("bit_value", 16'(want.bit_value), 16'(rsp_tdata[0]));
            check_field("pause_ms", want.pause_ms, rsp_tdata[16:1]);
            check_field("last", 16'(want.last), 16'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d of %0d words sent, %0d results pending",
                  $time, cycles, words_sent, words_total, expected_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int directed_words;
      int r;
      int len;
      logic [7:0] stray;

      // Standard block with both data extremes, then its pause
      push_word(ID_STANDARD);
      push_word(8'h34);
      push_word(8'h12);
      push_word(8'h02);
      push_word(8'h00);
      push_word(8'h00);
      push_word(8'hFF);
      std_blocks++;
      // Zero-length standard block: pause on the high length byte
      push_standard(16'hFFFF, 16'd0);
      push_pause(16'h0000);
      push_word(8'h00);
      push_word(8'hFF);
      stray_ids += 2;
      // Zero-length turbo block: nothing comes out
      push_turbo(24'd0);
      directed_words = tape_words.size();

      while (tape_words.size() < directed_words + RANDOM_WORDS) begin
         r = $urandom_range(0, 99);
         len = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 5);
         if (r < 35) begin
            push_standard(16'($urandom_range(0, 65535)), 16'(len));
         end else if (r < 60) begin
            push_turbo(24'(len));
         end else if (r < 80) begin
            push_pause(($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535)));
         end else begin
            // Unknown IDs are dropped by the parser
            do
               stray = 8'($urandom_range(0, 255));
            while (stray == ID_STANDARD || stray == ID_TURBO || stray == ID_PAUSE);
            push_word(stray);
            stray_ids++;
         end
      end
      words_total = tape_words.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (words_sent < words_total || expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d standard, %0d turbo and %0d pause blocks plus %0d unknown IDs",
               std_blocks, turbo_blocks, pause_blocks, stray_ids);
      $display("Sent %0d words, checked %0d result words, %0d errors",
               words_sent, results_seen, errors);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
